// ===== rtl/area_average_image_downscaler_core_defines.svh =====
// Assertion macros used by the downscaler core RTL.
`ifndef AREA_AVERAGE_IMAGE_DOWNSCALER_CORE_DEFINES_SVH
`define AREA_AVERAGE_IMAGE_DOWNSCALER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AAD_ASSERT_NOW(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("assertion failed");
`define AAD_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define AAD_ASSERT_NOW(lbl, clk, rstn, a, b)
`define AAD_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

// ===== rtl/aad_pkg.sv =====
package aad_pkg;

    localparam int DEF_MAX_SOURCE_WIDTH = 4096;
    localparam int DEF_MAX_SHRINK       = 4;
    localparam int DEF_CHANNEL_BITS     = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int SRC_W_BITS     = 13;
    localparam int SRC_H_BITS     = 16;
    localparam int SHRINK_BITS    = 3;
    localparam int FIELD_BITS     = 16;
    localparam int OUT_COL_BITS   = 12;
    localparam int OUT_ROW_BITS   = 16;
    localparam int IN_DATA_BITS   = 48;
    localparam int OUT_DATA_BITS  = 80;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHRINK        = 2'd2;

    localparam logic [SRC_W_BITS-1:0]  RST_SOURCE_WIDTH  = 13'd1;
    localparam logic [SRC_H_BITS-1:0]  RST_SOURCE_HEIGHT = 16'd1;
    localparam logic [SHRINK_BITS-1:0] RST_SHRINK        = 3'd2;

    typedef enum logic {
        FR_ACCEPT,
        FR_MERGE
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic push;
        logic full;
        logic empty;
        logic pop;
    } queue_ctl_t;

endpackage

// ===== rtl/aad_queue.sv =====
module aad_queue import aad_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;

endmodule

// ===== rtl/aad_front.sv =====
module aad_front import aad_pkg::*; #(
    parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_SHRINK       = DEF_MAX_SHRINK,
    parameter int CHANNEL_BITS     = DEF_CHANNEL_BITS,
    parameter int ENTRY_BITS       = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,
    input  logic                      q_full,
    output logic                      q_push,
    output logic [ENTRY_BITS-1:0]     q_data
);

    localparam int CNT_BITS = $clog2(MAX_SHRINK * MAX_SHRINK + 1);
    localparam int SUM_BITS = CHANNEL_BITS + CNT_BITS;
    localparam int AW       = $clog2(MAX_SOURCE_WIDTH);
    localparam int PW_BITS  = $clog2(MAX_SHRINK + 1);
    localparam int RW       = 17;
    localparam int RSH      = RW + 4;

    localparam logic [RSH-1:0] RECIP3 = RSH'((2**RSH + 2) / 3);
    localparam logic [RSH-1:0] RECIP5 = RSH'((2**RSH + 4) / 5);
    localparam logic [RSH-1:0] RECIP6 = RSH'((2**RSH + 5) / 6);
    localparam logic [RSH-1:0] RECIP7 = RSH'((2**RSH + 6) / 7);

    function automatic logic [RW-1:0] ceil_div(input logic [RW-1:0] n, input logic [3:0] d);
        logic [RW:0]     t;
        logic [RSH-1:0]  recip;
        logic [RW+RSH:0] prod;
        begin
            t = {1'b0, n} + (RW+1)'(d) - (RW+1)'(1);
            case (d)
                4'd3:    recip = RECIP3;
                4'd5:    recip = RECIP5;
                4'd6:    recip = RECIP6;
                4'd7:    recip = RECIP7;
                default: recip = '0;
            endcase
            prod = (RW+RSH+1)'(t) * (RW+RSH+1)'(recip);
            case (d)
                4'd2:                   ceil_div = RW'(t >> 1);
                4'd3, 4'd5, 4'd6, 4'd7: ceil_div = RW'(prod >> RSH);
                4'd4:                   ceil_div = RW'(t >> 2);
                4'd8:                   ceil_div = RW'(t >> 3);
                default:                ceil_div = n;
            endcase
        end
    endfunction

    function automatic logic [RW+3:0] split(input logic [RW-1:0] n, input logic [RW-1:0] m);
        logic [RW-1:0] r;
        logic [3:0]    q;
        begin
            r = n;
            q = 4'd0;
            for (int i = 0; i < MAX_SHRINK; i++) begin
                if (r >= m) begin
                    r = r - m;
                    q = q + 4'd1;
                end
            end
            split = {q, r};
        end
    endfunction

    logic [SRC_W_BITS-1:0]  cfg_w_reg;
    logic [SRC_H_BITS-1:0]  cfg_h_reg;
    logic [SHRINK_BITS-1:0] cfg_d_reg;
    logic [2:0]             settle_reg;

    logic [RW-1:0] w_eff_reg, h_eff_reg, ow_reg, oh_reg;
    logic [3:0]    d_eff_reg;
    logic [RW-1:0] rc_reg, rr_reg;
    logic [3:0]    qc_reg, qr_reg;
    logic [RW+3:0] split_c, split_r;

    front_state_t state_reg, state_next;

    logic [RW-1:0] src_col_reg, src_col_next, bin_col_reg, bin_col_next;
    logic [RW-1:0] col_end_reg, col_end_next, col_rem_reg, col_rem_next;
    logic [RW-1:0] src_row_reg, src_row_next, bin_row_reg, bin_row_next;
    logic [RW-1:0] row_end_reg, row_end_next, row_rem_reg, row_rem_next;
    logic [RW-1:0] row_start_reg, row_start_next;
    logic [SUM_BITS-1:0] psum_reg [3];
    logic [SUM_BITS-1:0] psum_next [3];
    logic [SUM_BITS-1:0] psum_add [3];
    logic [PW_BITS-1:0]  pw_reg, pw_next, pw_add;

    logic [SUM_BITS-1:0] hold_reg [3];
    logic                first_reg, lastrow_reg, flast_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [AW-1:0]       slot_reg;
    logic [OUT_COL_BITS-1:0] ocol_reg;
    logic [OUT_ROW_BITS-1:0] orow_reg;

    logic [3*SUM_BITS-1:0] mem [MAX_SOURCE_WIDTH];
    logic [3*SUM_BITS-1:0] rdata_reg, wdata;
    logic                  accept, col_hit, load;
    logic [RW-1:0]         rows, col_rsum, row_rsum;
    logic [RW+PW_BITS-1:0] count_wide;
    logic [SUM_BITS-1:0]   total [3];

    assign accept = s_tvalid && s_tready;
    assign load   = settle_reg == 3'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg  <= RST_SOURCE_WIDTH;
            cfg_h_reg  <= RST_SOURCE_HEIGHT;
            cfg_d_reg  <= RST_SHRINK;
            settle_reg <= 3'd4;
        end else if (cfg_wr_en && (cfg_index == CFG_SOURCE_WIDTH ||
                     cfg_index == CFG_SOURCE_HEIGHT || cfg_index == CFG_SHRINK)) begin
            if (cfg_index == CFG_SOURCE_WIDTH)  cfg_w_reg <= cfg_wdata[SRC_W_BITS-1:0];
            if (cfg_index == CFG_SOURCE_HEIGHT) cfg_h_reg <= cfg_wdata[SRC_H_BITS-1:0];
            if (cfg_index == CFG_SHRINK)        cfg_d_reg <= cfg_wdata[SHRINK_BITS-1:0];
            settle_reg <= 3'd4;
        end else if (settle_reg != 3'd0) begin
            settle_reg <= settle_reg - 3'd1;
        end
    end

    assign split_c = split(w_eff_reg, ow_reg);
    assign split_r = split(h_eff_reg, oh_reg);

    always_ff @(posedge aclk) begin
        if (cfg_w_reg == '0) begin
            w_eff_reg <= RW'(1);
        end else if (RW'(cfg_w_reg) > RW'(MAX_SOURCE_WIDTH)) begin
            w_eff_reg <= RW'(MAX_SOURCE_WIDTH);
        end else begin
            w_eff_reg <= RW'(cfg_w_reg);
        end
        h_eff_reg <= (cfg_h_reg == '0) ? RW'(1) : RW'(cfg_h_reg);
        if (cfg_d_reg == '0) begin
            d_eff_reg <= 4'd1;
        end else if (4'(cfg_d_reg) > 4'(MAX_SHRINK)) begin
            d_eff_reg <= 4'(MAX_SHRINK);
        end else begin
            d_eff_reg <= 4'(cfg_d_reg);
        end
        ow_reg <= ceil_div(w_eff_reg, d_eff_reg);
        oh_reg <= ceil_div(h_eff_reg, d_eff_reg);
        qc_reg <= split_c[RW+3:RW];
        rc_reg <= split_c[RW-1:0];
        qr_reg <= split_r[RW+3:RW];
        rr_reg <= split_r[RW-1:0];
    end

    always_comb begin
        unique case (state_reg)
            FR_ACCEPT: state_next = (accept && col_hit) ? FR_MERGE : FR_ACCEPT;
            FR_MERGE:  state_next = FR_ACCEPT;
            default:   state_next = FR_ACCEPT;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == FR_ACCEPT) && (settle_reg == 3'd0) && !q_full;
        q_push   = (state_reg == FR_MERGE) && lastrow_reg;
    end

    assign col_hit    = (src_col_reg + RW'(1)) >= col_end_reg;
    assign rows       = row_end_reg - row_start_reg;
    assign pw_add     = pw_reg + PW_BITS'(1);
    assign count_wide = (RW+PW_BITS)'(pw_add) * (RW+PW_BITS)'(rows);
    assign col_rsum   = col_rem_reg + rc_reg;
    assign row_rsum   = row_rem_reg + rr_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            psum_add[c] = psum_reg[c] +
                SUM_BITS'(s_tdata[c*FIELD_BITS +: CHANNEL_BITS]);
        end
        src_col_next   = src_col_reg;
        bin_col_next   = bin_col_reg;
        col_end_next   = col_end_reg;
        col_rem_next   = col_rem_reg;
        src_row_next   = src_row_reg;
        bin_row_next   = bin_row_reg;
        row_end_next   = row_end_reg;
        row_rem_next   = row_rem_reg;
        row_start_next = row_start_reg;
        psum_next      = psum_reg;
        pw_next        = pw_reg;
        if (load) begin
            src_col_next   = '0;
            bin_col_next   = '0;
            col_end_next   = RW'(qc_reg);
            col_rem_next   = rc_reg;
            src_row_next   = '0;
            bin_row_next   = '0;
            row_start_next = '0;
            row_end_next   = RW'(qr_reg);
            row_rem_next   = rr_reg;
            for (int c = 0; c < 3; c++) psum_next[c] = '0;
            pw_next = '0;
        end else if (accept) begin
            if (col_hit) begin
                for (int c = 0; c < 3; c++) psum_next[c] = '0;
                pw_next      = '0;
                bin_col_next = bin_col_reg + RW'(1);
                if (col_rsum >= ow_reg) begin
                    col_rem_next = col_rsum - ow_reg;
                    col_end_next = col_end_reg + RW'(qc_reg) + RW'(1);
                end else begin
                    col_rem_next = col_rsum;
                    col_end_next = col_end_reg + RW'(qc_reg);
                end
            end else begin
                psum_next = psum_add;
                pw_next   = pw_add;
            end
            if ((src_col_reg + RW'(1)) >= w_eff_reg) begin
                src_col_next = '0;
                bin_col_next = '0;
                col_end_next = RW'(qc_reg);
                col_rem_next = rc_reg;
                if ((src_row_reg + RW'(1)) >= h_eff_reg) begin
                    src_row_next   = '0;
                    bin_row_next   = '0;
                    row_start_next = '0;
                    row_end_next   = RW'(qr_reg);
                    row_rem_next   = rr_reg;
                end else begin
                    if ((src_row_reg + RW'(1)) >= row_end_reg) begin
                        bin_row_next   = bin_row_reg + RW'(1);
                        row_start_next = row_end_reg;
                        if (row_rsum >= oh_reg) begin
                            row_rem_next = row_rsum - oh_reg;
                            row_end_next = row_end_reg + RW'(qr_reg) + RW'(1);
                        end else begin
                            row_rem_next = row_rsum;
                            row_end_next = row_end_reg + RW'(qr_reg);
                        end
                    end
                    src_row_next = src_row_reg + RW'(1);
                end
            end else begin
                src_col_next = src_col_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FR_ACCEPT;
            src_col_reg   <= '0;
            bin_col_reg   <= '0;
            col_end_reg   <= '0;
            col_rem_reg   <= '0;
            src_row_reg   <= '0;
            bin_row_reg   <= '0;
            row_end_reg   <= '0;
            row_rem_reg   <= '0;
            row_start_reg <= '0;
            pw_reg        <= '0;
            for (int c = 0; c < 3; c++) psum_reg[c] <= '0;
        end else begin
            state_reg     <= state_next;
            src_col_reg   <= src_col_next;
            bin_col_reg   <= bin_col_next;
            col_end_reg   <= col_end_next;
            col_rem_reg   <= col_rem_next;
            src_row_reg   <= src_row_next;
            bin_row_reg   <= bin_row_next;
            row_end_reg   <= row_end_next;
            row_rem_reg   <= row_rem_next;
            row_start_reg <= row_start_next;
            pw_reg        <= pw_next;
            psum_reg      <= psum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && col_hit) begin
            hold_reg    <= psum_add;
            first_reg   <= src_row_reg == row_start_reg;
            lastrow_reg <= (src_row_reg + RW'(1)) >= row_end_reg;
            count_reg   <= (count_wide == '0) ? CNT_BITS'(1) : CNT_BITS'(count_wide);
            slot_reg    <= bin_col_reg[AW-1:0];
            ocol_reg    <= OUT_COL_BITS'(bin_col_reg);
            orow_reg    <= OUT_ROW_BITS'(bin_row_reg);
            flast_reg   <= ((bin_col_reg + RW'(1)) == ow_reg) &&
                           ((bin_row_reg + RW'(1)) == oh_reg);
            rdata_reg   <= mem[bin_col_reg[AW-1:0]];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            total[c] = (first_reg ? '0 : rdata_reg[c*SUM_BITS +: SUM_BITS]) + hold_reg[c];
            wdata[c*SUM_BITS +: SUM_BITS] = total[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == FR_MERGE) begin
            mem[slot_reg] <= wdata;
        end
    end

    assign q_data = {flast_reg, orow_reg, ocol_reg, count_reg, wdata};

endmodule

// ===== rtl/aad_back.sv =====
module aad_back import aad_pkg::*; #(
    parameter int MAX_SHRINK   = DEF_MAX_SHRINK,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
    parameter int ENTRY_BITS   = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_empty,
    output logic                     q_pop,
    input  logic [ENTRY_BITS-1:0]    q_data,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic                     m_tlast
);

    localparam int CNT_BITS = $clog2(MAX_SHRINK * MAX_SHRINK + 1);
    localparam int SUM_BITS = CHANNEL_BITS + CNT_BITS;
    localparam int DVB      = SUM_BITS + 1;
    localparam int REM_BITS = CNT_BITS + 1;
    localparam int IT_BITS  = $clog2(DVB + 1);

    back_state_t state_reg, state_next;

    logic [REM_BITS+DVB-1:0] work_reg [3];
    logic [REM_BITS+DVB-1:0] work_next [3];
    logic [CNT_BITS-1:0]     count_reg;
    logic [IT_BITS-1:0]      iter_reg;
    logic [OUT_COL_BITS-1:0] ocol_reg;
    logic [OUT_ROW_BITS-1:0] orow_reg;
    logic                    flast_reg;
    logic [REM_BITS+DVB-1:0] shifted [3];
    logic [REM_BITS-1:0]     top [3];
    logic [CNT_BITS-1:0]     in_count;

    assign in_count = q_data[3*SUM_BITS +: CNT_BITS];

    always_comb begin
        unique case (state_reg)
            BK_IDLE: state_next = q_empty ? BK_IDLE : BK_DIV;
            BK_DIV:  state_next = (iter_reg == IT_BITS'(1)) ? BK_OUT : BK_DIV;
            BK_OUT:  state_next = m_tready ? BK_IDLE : BK_OUT;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = (state_reg == BK_IDLE) && !q_empty;
        m_tvalid = state_reg == BK_OUT;
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            shifted[c] = work_reg[c] << 1;
            top[c]     = shifted[c][REM_BITS+DVB-1:DVB];
            work_next[c] = shifted[c];
            if (top[c] >= REM_BITS'(count_reg)) begin
                work_next[c][REM_BITS+DVB-1:DVB] = top[c] - REM_BITS'(count_reg);
                work_next[c][0] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            for (int c = 0; c < 3; c++) begin
                work_reg[c] <= {{REM_BITS{1'b0}},
                    DVB'(q_data[c*SUM_BITS +: SUM_BITS]) + DVB'(in_count >> 1)};
            end
            count_reg <= in_count;
            iter_reg  <= IT_BITS'(DVB);
            ocol_reg  <= q_data[3*SUM_BITS+CNT_BITS +: OUT_COL_BITS];
            orow_reg  <= q_data[3*SUM_BITS+CNT_BITS+OUT_COL_BITS +: OUT_ROW_BITS];
            flast_reg <= q_data[ENTRY_BITS-1];
        end else if (state_reg == BK_DIV) begin
            work_reg <= work_next;
            iter_reg <= iter_reg - IT_BITS'(1);
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int c = 0; c < 3; c++) begin
            m_tdata[c*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(work_reg[c][CHANNEL_BITS-1:0]);
        end
        m_tdata[3*FIELD_BITS +: OUT_COL_BITS] = ocol_reg;
        m_tdata[3*FIELD_BITS+OUT_COL_BITS +: OUT_ROW_BITS] = orow_reg;
        m_tlast = flast_reg;
    end

endmodule

// ===== rtl/area_average_image_downscaler_core.sv =====
// Throughput: one pixel per cycle while s_tready is high; s_tready is low in the merge
// state after a pixel that closes a column bin and while the queue is full. Each finished
// bin goes through the bit-serial divider, which pops the next bin only after the previous
// result word is accepted. A closing pixel's sum passes the merge registers, queue and divider.
// Reset is synchronous and active low; it and every width, height or shrink register write
// hold s_tready low while the bin geometry is recomputed.
`include "area_average_image_downscaler_core_defines.svh"
module area_average_image_downscaler_core import aad_pkg::*; #(
    parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_SHRINK       = DEF_MAX_SHRINK,
    parameter int CHANNEL_BITS     = DEF_CHANNEL_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // red_in, green_in, blue_in
    input  logic [IN_DATA_BITS-1:0]   s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // red_out, green_out, blue_out, out_column, out_row, zero fill
    output logic [OUT_DATA_BITS-1:0]  m_tdata,
    output logic                      m_tlast
);

    localparam int CNT_BITS   = $clog2(MAX_SHRINK * MAX_SHRINK + 1);
    localparam int SUM_BITS   = CHANNEL_BITS + CNT_BITS;
    localparam int ENTRY_BITS = 3 * SUM_BITS + CNT_BITS + OUT_COL_BITS + OUT_ROW_BITS + 1;

    logic                  q_push, q_pop, q_full, q_empty;
    logic [ENTRY_BITS-1:0] push_data, pop_data;

    aad_front #(
        .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH),
        .MAX_SHRINK(MAX_SHRINK),
        .CHANNEL_BITS(CHANNEL_BITS),
        .ENTRY_BITS(ENTRY_BITS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_full(q_full), .q_push(q_push), .q_data(push_data)
    );

    aad_queue #(.WIDTH(ENTRY_BITS)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(push_data),
        .pop(q_pop), .pop_data(pop_data),
        .full(q_full), .empty(q_empty)
    );

    aad_back #(
        .MAX_SHRINK(MAX_SHRINK),
        .CHANNEL_BITS(CHANNEL_BITS),
        .ENTRY_BITS(ENTRY_BITS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_pop(q_pop), .q_data(pop_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    `AAD_ASSERT_NOW(a_no_overflow, aclk, aresetn, q_push, !q_full)
    `AAD_ASSERT_NOW(a_no_underflow, aclk, aresetn, q_pop, !q_empty)
    `AAD_ASSERT_NEXT(a_cfg_stalls, aclk, aresetn, cfg_wr_en && cfg_index == CFG_SHRINK, !s_tready)

endmodule
